// ===== src/lsac_pkg.sv =====
// Shared types and constants for the limit switch arm controller.
// No dependencies; used by every module of the block.
package lsac_pkg;

	// Configuration register file
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_HOLDOFF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_HOLDOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD   = 2'd2;

	localparam logic [CFG_W-1:0] START_HOLDOFF_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] TOGGLE_HOLDOFF_RST = 16'd500;
	localparam logic [CFG_W-1:0] BLINK_PERIOD_RST   = 16'd200;

	// Mode codes
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_STOPPED = 3'd0;
	localparam logic [MODE_W-1:0] MODE_IN      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OUT     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLOSED  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ERROR   = 3'd5;

	// Serial move command characters
	localparam logic [7:0] CHAR_MOVE_LO = 8'h6F; // 'o'
	localparam logic [7:0] CHAR_MOVE_UP = 8'h4F; // 'O'

	// Sensor inputs of one tick
	typedef struct packed {
		logic lim_in;
		logic lim_out;
		logic sw_act;
		logic expired;
	} tick_t;

	// Mode machine decision for one tick
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              relay;
		logic              reload;
		logic              reload_start;
	} mode_upd_t;

endpackage

// ===== src/lsac_mode.sv =====
// Next-mode logic of the arm controller: six-state machine with relay level.
// Depends on lsac_pkg.
module lsac_mode (
	input  logic [lsac_pkg::MODE_W-1:0] mode,
	input  logic                        relay,
	input  lsac_pkg::tick_t             tick,
	output lsac_pkg::mode_upd_t         upd
);

	logic both;
	logic go;

	assign both = tick.lim_in && tick.lim_out;
	assign go   = tick.sw_act && tick.expired;

	// Mode transitions; a switch-driven move asks for a hold-off reload
	always_comb begin
		upd.mode         = mode;
		upd.relay        = relay;
		upd.reload       = 1'b0;
		upd.reload_start = 1'b0;
		unique case (mode)
			lsac_pkg::MODE_STOPPED: begin
				upd.relay = 1'b0;
				if (both) begin
					upd.mode = lsac_pkg::MODE_ERROR;
				end else if (tick.lim_in) begin
					upd.mode = lsac_pkg::MODE_CLOSED;
				end else if (tick.lim_out) begin
					upd.mode = lsac_pkg::MODE_OPEN;
				end else if (go) begin
					upd.reload       = 1'b1;
					upd.reload_start = 1'b1;
					upd.mode         = lsac_pkg::MODE_OUT;
				end
			end
			lsac_pkg::MODE_IN: begin
				if (both) begin
					upd.mode = lsac_pkg::MODE_ERROR;
				end else begin
					upd.relay = 1'b0;
					if (tick.lim_in)
						upd.mode = lsac_pkg::MODE_CLOSED;
				end
			end
			lsac_pkg::MODE_OUT: begin
				if (both) begin
					upd.mode = lsac_pkg::MODE_ERROR;
				end else begin
					upd.relay = 1'b1;
					if (go) begin
						upd.reload = 1'b1;
						upd.mode   = lsac_pkg::MODE_STOPPED;
					end else if (tick.lim_out) begin
						upd.mode = lsac_pkg::MODE_OPEN;
					end
				end
			end
			lsac_pkg::MODE_CLOSED: begin
				if (both) begin
					upd.mode = lsac_pkg::MODE_ERROR;
				end else begin
					upd.relay = 1'b0;
					if (go) begin
						upd.reload = 1'b1;
						upd.mode   = lsac_pkg::MODE_OUT;
					end
				end
			end
			lsac_pkg::MODE_OPEN: begin
				if (both) begin
					upd.mode = lsac_pkg::MODE_ERROR;
				end else begin
					upd.relay = 1'b1;
					if (go) begin
						upd.reload = 1'b1;
						upd.mode   = lsac_pkg::MODE_IN;
					end
				end
			end
			lsac_pkg::MODE_ERROR: begin
				upd.relay = 1'b0;
				if (tick.lim_in && !tick.lim_out)
					upd.mode = lsac_pkg::MODE_CLOSED;
				else if (!tick.lim_in && tick.lim_out)
					upd.mode = lsac_pkg::MODE_OPEN;
				else if (!tick.lim_in && !tick.lim_out)
					upd.mode = lsac_pkg::MODE_STOPPED;
			end
			default: begin
				// unused codes hold everything
			end
		endcase
	end

endmodule

// ===== src/lsac_blink.sv =====
// LED blink divider: countdown, 3-bit phase and LED level chosen by mode.
// Depends on lsac_pkg.
module lsac_blink #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [lsac_pkg::CFG_W-1:0]  blink_period,
	input  logic [lsac_pkg::MODE_W-1:0] mode_next,
	output logic                        led
);

	localparam int WW = lsac_pkg::CFG_W + TIMER_WIDTH;

	logic [TIMER_WIDTH-1:0] count_q;
	logic [2:0]             phase_q;
	logic                   led_q;
	logic [TIMER_WIDTH-1:0] period_load;
	logic [WW-1:0]          period_wide;
	logic                   led_next;

	// Period saturates at the counter maximum
	assign period_wide = {{TIMER_WIDTH{1'b0}}, blink_period};
	always_comb begin
		if (period_wide > {{lsac_pkg::CFG_W{1'b0}}, {TIMER_WIDTH{1'b1}}})
			period_load = {TIMER_WIDTH{1'b1}};
		else
			period_load = period_wide[TIMER_WIDTH-1:0];
	end

	// LED level from the old phase bits
	always_comb begin
		led_next = led_q;
		case (mode_next)
			lsac_pkg::MODE_IN:     led_next = phase_q[2];
			lsac_pkg::MODE_OUT:    led_next = phase_q[1];
			lsac_pkg::MODE_CLOSED: led_next = 1'b0;
			lsac_pkg::MODE_OPEN:   led_next = 1'b1;
			lsac_pkg::MODE_ERROR:  led_next = phase_q[1] & phase_q[0];
			default:               led_next = led_q;
		endcase
	end

	// Divider step once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
			led_q   <= 1'b0;
		end else if (step) begin
			if (count_q == '0) begin
				count_q <= period_load;
				phase_q <= phase_q + 3'd1;
				led_q   <= led_next;
			end else begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign led = led_q;

endmodule

// ===== src/limit_switch_arm_controller.sv =====
// Limit switch arm controller (top level): one result beat per tick beat.
// Depends on lsac_pkg, lsac_mode and lsac_blink.
//
// Each input beat is one millisecond tick with the two limit sensors, the switch and
// an optional serial byte; an 'o' or 'O' latches a move command. The tick is folded
// into the mode, hold-off, command, relay and blink registers in the cycle it is
// accepted, and those registers are the result beat (relay_drive, led_on, mode_code)
// shown with out_valid on the next cycle. One tick per clock is sustained: the only
// thing that holds in_ready low is a result beat that is still not taken.
// Configuration writes take effect on the next tick.
module limit_switch_arm_controller #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [lsac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsac_pkg::CFG_W-1:0]     cfg_data,
	// tick channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           limit_in_active,
	input  logic                           limit_out_active,
	input  logic                           switch_pressed,
	input  logic                           byte_valid,
	input  logic [7:0]                     rx_byte,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           relay_drive,
	output logic                           led_on,
	output logic [2:0]                     mode_code
);

	localparam int WW = lsac_pkg::CFG_W + TIMER_WIDTH;

	logic [lsac_pkg::CFG_W-1:0]  start_holdoff_q;
	logic [lsac_pkg::CFG_W-1:0]  toggle_holdoff_q;
	logic [lsac_pkg::CFG_W-1:0]  blink_period_q;

	logic [lsac_pkg::MODE_W-1:0] mode_q;
	logic [TIMER_WIDTH-1:0]      hold_q;
	logic                        cmd_q;
	logic                        relay_q;
	logic                        out_valid_q;

	logic                        accept;
	logic                        cmd_set;
	logic                        cmd_now;
	logic [lsac_pkg::CFG_W-1:0]  holdoff_sel;
	logic [WW-1:0]               holdoff_wide;
	logic [TIMER_WIDTH-1:0]      holdoff_load;
	logic [TIMER_WIDTH-1:0]      hold_next;
	lsac_pkg::tick_t             tick;
	lsac_pkg::mode_upd_t         upd;

	// Handshake: a new tick goes in whenever the result slot is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_holdoff_q  <= lsac_pkg::START_HOLDOFF_RST;
			toggle_holdoff_q <= lsac_pkg::TOGGLE_HOLDOFF_RST;
			blink_period_q   <= lsac_pkg::BLINK_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsac_pkg::CFG_START_HOLDOFF:  start_holdoff_q  <= cfg_data;
				lsac_pkg::CFG_TOGGLE_HOLDOFF: toggle_holdoff_q <= cfg_data;
				lsac_pkg::CFG_BLINK_PERIOD:   blink_period_q   <= cfg_data;
				default: begin
					// index beyond the register file is ignored
				end
			endcase
		end
	end

	// Command latch and switch activity
	assign cmd_set = byte_valid &&
		(rx_byte == lsac_pkg::CHAR_MOVE_LO || rx_byte == lsac_pkg::CHAR_MOVE_UP);
	assign cmd_now = cmd_q || cmd_set;

	assign tick.lim_in  = limit_in_active;
	assign tick.lim_out = limit_out_active;
	assign tick.sw_act  = switch_pressed || cmd_now;
	assign tick.expired = (hold_q == '0);

	lsac_mode u_mode (
		.mode  (mode_q),
		.relay (relay_q),
		.tick  (tick),
		.upd   (upd)
	);

	// Hold-off reload value, saturated at the counter maximum
	assign holdoff_sel  = upd.reload_start ? start_holdoff_q : toggle_holdoff_q;
	assign holdoff_wide = {{TIMER_WIDTH{1'b0}}, holdoff_sel};
	always_comb begin
		if (holdoff_wide > {{lsac_pkg::CFG_W{1'b0}}, {TIMER_WIDTH{1'b1}}})
			holdoff_load = {TIMER_WIDTH{1'b1}};
		else
			holdoff_load = holdoff_wide[TIMER_WIDTH-1:0];
	end

	always_comb begin
		if (upd.reload)
			hold_next = holdoff_load;
		else if (tick.expired)
			hold_next = hold_q;
		else
			hold_next = hold_q - 1'b1;
	end

	// Tick state, which is also the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lsac_pkg::MODE_STOPPED;
			hold_q  <= '0;
			cmd_q   <= 1'b0;
			relay_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= upd.mode;
			hold_q  <= hold_next;
			cmd_q   <= cmd_now && !upd.reload;
			relay_q <= upd.relay;
		end
	end

	lsac_blink #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_blink (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.blink_period (blink_period_q),
		.mode_next    (upd.mode),
		.led          (led_on)
	);

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign relay_drive = relay_q;
	assign mode_code   = mode_q;

`ifndef SYNTHESIS
	// the state never moves while a result beat is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mode_code) && $stable(relay_drive) && $stable(led_on))
		else $error("result beat changed while stalled");

	// mode register holds a defined code
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= lsac_pkg::MODE_ERROR)
		else $error("mode register holds an undefined code");

	// the relay is never energized once fully closed
	a_closed_relay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_code == lsac_pkg::MODE_CLOSED |-> !relay_drive)
		else $error("relay energized in closed mode");

	// a switch-driven move always clears the latched command
	a_reload_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && upd.reload |=> !cmd_q)
		else $error("command still pending after a switch-driven move");
`endif

endmodule
